// ===== hw/rtl/ssg_pkg.sv =====
// Shared constants, types and the sine table function of the sine and space-vector PWM generator.
package ssg_pkg;

	// Default address width of the full-turn sine table.
	localparam int TABLE_ADDR_BITS_DEF = 10;

	// Phase offsets of one third and two thirds of a turn.
	localparam logic [15:0] SHIFT_120 = 16'd21845;
	localparam logic [15:0] SHIFT_240 = 16'd43690;

	// Reset values of the configuration registers.
	localparam logic        SVPWM_ENABLE_RST    = 1'b1;
	localparam logic [15:0] BOOST_AMPLITUDE_RST = 16'd2000;
	localparam logic [14:0] BOOST_FREQ_RST      = 15'd1;
	localparam logic [15:0] MAX_AMPLITUDE_RST   = 16'd37810;
	localparam logic [14:0] WEAK_FREQ_RST       = 15'd120;
	localparam logic [15:0] SLEW_PERIOD_RST     = 16'd100;

	// Configuration register indexes on the APB port.
	typedef enum logic [2:0] {
		REG_SVPWM_ENABLE    = 3'd0,
		REG_BOOST_AMPLITUDE = 3'd1,
		REG_BOOST_FREQ      = 3'd2,
		REG_MAX_AMPLITUDE   = 3'd3,
		REG_WEAK_FREQ       = 3'd4,
		REG_SLEW_PERIOD     = 3'd5
	} reg_idx_t;

	// Response of the serial divider.
	typedef struct packed {
		logic        done;
		logic [15:0] quot;
	} div_rsp_t;

	// Fixed-point constants of the quarter-wave polynomial.
	localparam longint unsigned ONE_Q30     = 64'd1 << 30;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Magnitude of the sine sample at quarter-wave position u, with 2**qbits steps per quarter.
	// It is only evaluated at elaboration to build the constant table.
	function automatic logic [14:0] sine_mag(input int unsigned u, input int unsigned qbits);
		longint unsigned th;
		longint unsigned t2;
		longint unsigned p;
		longint unsigned s;
		longint unsigned mag;
		th = (longint'(u) * HALF_PI_Q30) >> qbits;
		t2 = (th * th) >> 30;
		p = ONE_Q30;
		p = ONE_Q30 - ((t2 * p) >> 30) / 110;
		p = ONE_Q30 - ((t2 * p) >> 30) / 72;
		p = ONE_Q30 - ((t2 * p) >> 30) / 42;
		p = ONE_Q30 - ((t2 * p) >> 30) / 20;
		p = ONE_Q30 - ((t2 * p) >> 30) / 6;
		s = (th * p) >> 30;
		mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		return mag[14:0];
	endfunction

endpackage

// ===== hw/rtl/ssg_sine_rom.sv =====
// Quarter-wave sine table with a registered signed sample output.
module ssg_sine_rom #(
	parameter int ADDR_BITS = ssg_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic               clk,
	input  logic [15:0]        phase,
	output logic signed [15:0] sample
);

	localparam int QBITS   = ADDR_BITS - 2;
	localparam int QUARTER = 1 << QBITS;
	localparam logic [14:0] PEAK = ssg_pkg::sine_mag(QUARTER, QBITS);

	logic [14:0]          mag_tab [QUARTER];
	logic [ADDR_BITS-1:0] idx;
	logic [1:0]           quad;
	logic [QBITS-1:0]     r;
	logic [QBITS-1:0]     r_mirror;
	logic [14:0]          mag;

	// Constant quarter-wave magnitudes.
	for (genvar gi = 0; gi < QUARTER; gi++) begin : g_tab
		assign mag_tab[gi] = ssg_pkg::sine_mag(gi, QBITS);
	end

	// Fold the table index into the first quadrant.
	assign idx      = phase[15 -: ADDR_BITS];
	assign quad     = idx[ADDR_BITS-1 -: 2];
	assign r        = idx[QBITS-1:0];
	assign r_mirror = ~r + {{(QBITS-1){1'b0}}, 1'b1};

	always_comb begin
		if (!quad[0]) begin
			mag = mag_tab[r];
		end else if (r == '0) begin
			mag = PEAK;
		end else begin
			mag = mag_tab[r_mirror];
		end
	end

	// The second half of the turn is negative.
	always_ff @(posedge clk) begin
		sample <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule

// ===== hw/rtl/ssg_divider.sv =====
// Serial restoring divider for the V/f slope, one quotient bit per cycle.
module ssg_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [16:0] num,
	input  logic [14:0]        den,
	output ssg_pkg::div_rsp_t  rsp
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [15:0] dvd_q;
	logic [14:0] rem_q;
	logic [14:0] den_q;
	logic        neg_q;
	logic [15:0] trial;
	logic        fits;
	logic [16:0] num_mag;

	// Magnitude of the dividend; the quotient is negated at the end.
	assign num_mag = num[16] ? -num : num;

	assign trial = {rem_q, dvd_q[15]};
	assign fits  = trial >= {1'b0, den_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the dividend out and the quotient bits in.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= num_mag[15:0];
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[16];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[14:0], fits};
			rem_q <= fits ? 15'(trial - {1'b0, den_q}) : trial[14:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -dvd_q : dvd_q;

endmodule

// ===== hw/rtl/sine_svpwm_generator.sv =====
// Top level of the sine and space-vector PWM generator: register port, sequencer, multiplier.
// Sequence: each accepted tick runs the table read, the multiply and the store once per phase, then the
// output step; a ramp step on the sloped part of the V/f curve first runs the 16 serial divider steps and
// the slope multiply. A new tick is taken only once the previous result has left the output step;
// the single multiplier runs once per phase and once for the slope.
// Reset: asynchronous, active low; clears the generator state and loads the register defaults.
module sine_svpwm_generator #(
	parameter int TABLE_ADDR_BITS = ssg_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// Tick input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] freq_setpoint,
	// Result output
	output logic               out_valid,
	input  logic               out_ready,
	output logic [10:0]        duty_a,
	output logic [10:0]        duty_b,
	output logic [10:0]        duty_c,
	output logic               trig_rising,
	output logic signed [15:0] current_freq
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DIV   = 8'b0000_0010,
		ST_VMUL  = 8'b0000_0100,
		ST_VAMP  = 8'b0000_1000,
		ST_ROM   = 8'b0001_0000,
		ST_SMUL  = 8'b0010_0000,
		ST_STORE = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic        svpwm_enable_q;
	logic [15:0] boost_amplitude_q;
	logic [14:0] boost_freq_q;
	logic [15:0] max_amplitude_q;
	logic [14:0] weak_freq_q;
	logic [15:0] slew_period_q;

	// Generator state
	logic [15:0]        phase_acc_q;
	logic signed [15:0] ramp_freq_q;
	logic [16:0]        slew_count_q;
	logic [15:0]        amplitude_q;

	// Sequencer data
	logic [1:0]         k_q;
	logic [14:0]        dist_q;
	logic [15:0]        slope_q;
	logic signed [32:0] product_q;
	logic signed [17:0] s_q [3];

	logic               wr_en;
	logic [2:0]         reg_idx;
	logic               in_xfer;
	logic               out_xfer;
	logic               load_out;
	logic               step;
	logic               on_line;
	logic signed [15:0] freq_prev;
	logic signed [15:0] sample;
	logic [15:0]        rom_phase;
	logic signed [16:0] op_a;
	logic signed [15:0] op_b;
	logic               div_start;
	ssg_pkg::div_rsp_t  div_rsp;

	assign pready   = 1'b1;
	assign reg_idx  = paddr[4:2];
	assign wr_en    = psel && penable && pwrite && pready;
	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign load_out = (state_q == ST_OUT) && (!out_valid || out_ready);

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			svpwm_enable_q    <= ssg_pkg::SVPWM_ENABLE_RST;
			boost_amplitude_q <= ssg_pkg::BOOST_AMPLITUDE_RST;
			boost_freq_q      <= ssg_pkg::BOOST_FREQ_RST;
			max_amplitude_q   <= ssg_pkg::MAX_AMPLITUDE_RST;
			weak_freq_q       <= ssg_pkg::WEAK_FREQ_RST;
			slew_period_q     <= ssg_pkg::SLEW_PERIOD_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				ssg_pkg::REG_SVPWM_ENABLE:    svpwm_enable_q    <= pwdata[0];
				ssg_pkg::REG_BOOST_AMPLITUDE: boost_amplitude_q <= pwdata[15:0];
				ssg_pkg::REG_BOOST_FREQ:      boost_freq_q      <= pwdata[14:0];
				ssg_pkg::REG_MAX_AMPLITUDE:   max_amplitude_q   <= pwdata[15:0];
				ssg_pkg::REG_WEAK_FREQ:       weak_freq_q       <= pwdata[14:0];
				ssg_pkg::REG_SLEW_PERIOD:     slew_period_q     <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Register reads.
	always_comb begin
		unique case (reg_idx)
			ssg_pkg::REG_SVPWM_ENABLE:    prdata = {31'd0, svpwm_enable_q};
			ssg_pkg::REG_BOOST_AMPLITUDE: prdata = {16'd0, boost_amplitude_q};
			ssg_pkg::REG_BOOST_FREQ:      prdata = {17'd0, boost_freq_q};
			ssg_pkg::REG_MAX_AMPLITUDE:   prdata = {16'd0, max_amplitude_q};
			ssg_pkg::REG_WEAK_FREQ:       prdata = {17'd0, weak_freq_q};
			ssg_pkg::REG_SLEW_PERIOD:     prdata = {16'd0, slew_period_q};
			default:                      prdata = '0;
		endcase
	end

	// Ramp step decision and V/f segment of the pre-step frequency.
	assign freq_prev = ramp_freq_q;
	assign step      = slew_count_q >= {1'b0, slew_period_q};
	assign on_line   = (freq_prev != 16'sd0) && !(freq_prev < $signed({1'b0, boost_freq_q}))
		&& (freq_prev < $signed({1'b0, weak_freq_q}));
	assign div_start = in_xfer && step && on_line;

	ssg_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ($signed({1'b0, max_amplitude_q}) - $signed({1'b0, boost_amplitude_q})),
		.den    (weak_freq_q - boost_freq_q),
		.rsp    (div_rsp)
	);

	// Table address for the phase selected by the sequencer.
	always_comb begin
		unique case (k_q)
			2'd1:    rom_phase = phase_acc_q + ssg_pkg::SHIFT_120;
			2'd2:    rom_phase = phase_acc_q + ssg_pkg::SHIFT_240;
			default: rom_phase = phase_acc_q;
		endcase
	end

	ssg_sine_rom #(
		.ADDR_BITS (TABLE_ADDR_BITS)
	) u_rom (
		.clk    (clk),
		.phase  (rom_phase),
		.sample (sample)
	);

	// Shared multiplier: slope times distance, or amplitude times sine sample.
	assign op_a = (state_q == ST_VMUL) ? $signed({1'b0, slope_q}) : $signed({1'b0, amplitude_q});
	assign op_b = (state_q == ST_VMUL) ? $signed({1'b0, dist_q}) : sample;

	always_ff @(posedge clk) begin
		product_q <= 33'(op_a) * 33'(op_b);
	end

	// Midpoint offset and duty values of the finished tick.
	logic signed [17:0] mn;
	logic signed [17:0] mx;
	logic signed [18:0] mid_sum;
	logic signed [17:0] ofs;
	logic [15:0]        d_a;
	logic [15:0]        d_b;
	logic [15:0]        d_c;
	logic signed [18:0] p_ext;
	logic signed [18:0] f_ext;
	logic signed [18:0] trig_lo;
	logic signed [18:0] trig_hi;
	logic               trig;

	always_comb begin
		mn = s_q[0];
		mx = s_q[0];
		if (s_q[1] < mn) mn = s_q[1];
		if (s_q[1] > mx) mx = s_q[1];
		if (s_q[2] < mn) mn = s_q[2];
		if (s_q[2] > mx) mx = s_q[2];
		mid_sum = 19'(mn) + 19'(mx);
		ofs     = svpwm_enable_q ? 18'(mid_sum >>> 1) : 18'sd0;
		d_a     = 16'(s_q[0] - ofs);
		d_b     = 16'(s_q[1] - ofs);
		d_c     = 16'(s_q[2] - ofs);
	end

	// Trigger window around a quarter turn.
	assign p_ext   = $signed({3'b000, phase_acc_q});
	assign f_ext   = 19'(ramp_freq_q);
	assign trig_lo = p_ext - f_ext + 19'sd1;
	assign trig_hi = p_ext + f_ext - 19'sd1;
	assign trig    = (trig_lo <= 19'sd16384) && (trig_hi >= 19'sd16384);

	// Sequencer and generator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_acc_q  <= '0;
			ramp_freq_q  <= '0;
			slew_count_q <= '0;
			amplitude_q  <= '0;
			k_q          <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (in_xfer) begin
						if (step) begin
							slew_count_q <= '0;
							if (ramp_freq_q < freq_setpoint) begin
								ramp_freq_q <= ramp_freq_q + 16'sd1;
							end else if (ramp_freq_q > freq_setpoint) begin
								ramp_freq_q <= ramp_freq_q - 16'sd1;
							end
							if (freq_prev == 16'sd0) begin
								amplitude_q <= '0;
							end else if (freq_prev < $signed({1'b0, boost_freq_q})) begin
								amplitude_q <= boost_amplitude_q;
							end else if (!on_line) begin
								amplitude_q <= max_amplitude_q;
							end
							state_q <= on_line ? ST_DIV : ST_ROM;
						end else begin
							slew_count_q <= slew_count_q + 17'd1;
							state_q      <= ST_ROM;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_VMUL;
					end
				end
				ST_VMUL: begin
					state_q <= ST_VAMP;
				end
				ST_VAMP: begin
					amplitude_q <= max_amplitude_q - product_q[15:0];
					state_q     <= ST_ROM;
				end
				ST_ROM: begin
					state_q <= ST_SMUL;
				end
				ST_SMUL: begin
					state_q <= ST_STORE;
				end
				ST_STORE: begin
					if (k_q == 2'd2) begin
						state_q <= ST_OUT;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_ROM;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						phase_acc_q <= phase_acc_q + ramp_freq_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result valid flag: set by the output step, cleared by a result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_xfer) begin
			out_valid <= 1'b0;
		end
	end

	// Sequencer data path registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dist_q <= 15'($signed({1'b0, weak_freq_q}) - freq_prev);
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			slope_q <= div_rsp.quot;
		end
		if (state_q == ST_STORE) begin
			s_q[k_q] <= product_q[32:15];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (load_out) begin
			duty_a       <= {~d_a[15], d_a[14:5]};
			duty_b       <= {~d_b[15], d_b[14:5]};
			duty_c       <= {~d_c[15], d_c[14:5]};
			trig_rising  <= trig;
			current_freq <= ramp_freq_q;
		end
	end

	// The block is busy right after taking a tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a tick is in progress");

	// The slew counter never passes the largest period.
	assert property (@(posedge clk) disable iff (!arst_n)
		!slew_count_q[16])
		else $error("slew counter overflow");

	// The divider only finishes while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider result outside the slope step");

	// A new result only comes from the output step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result valid without output step");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the sine and space-vector PWM generator.
`timescale 1ns / 100ps

module testbench;

	localparam int TAB_BITS = ssg_pkg::TABLE_ADDR_BITS_DEF;
	localparam int TAB_SIZE = 1 << TAB_BITS;
	localparam int TAB_QUARTER = TAB_SIZE / 4;
	localparam longint unsigned UNITY_Q30 = 64'd1 << 30;
	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
	localparam logic [15:0] PHASE_THIRD = 16'd21845;
	localparam logic [15:0] PHASE_TWO_THIRDS = 16'd43690;
	// Byte address of a register index past the last one.
	localparam logic [4:0] UNMAPPED_ADDR = 5'd24;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 500000;

	// One result transfer of the generator.
	typedef struct packed {
		logic [10:0]        duty_a;
		logic [10:0]        duty_b;
		logic [10:0]        duty_c;
		logic               trig_rising;
		logic signed [15:0] current_freq;
	} pwm_tick_t;

	// Scoreboard: mirrors registers and state, predicts each tick and checks the results.
	class pwm_scoreboard;
		logic [15:0] sine_tab [TAB_SIZE];
		logic        svpwm_en;
		logic [15:0] boost_amp;
		logic [14:0] boost_f;
		logic [15:0] max_amp;
		logic [14:0] weak_f;
		logic [15:0] slew_per;
		logic [15:0] phase;
		logic signed [15:0] ramp;
		logic [16:0] slew_cnt;
		logic [15:0] amp;
		pwm_tick_t   pending [$];
		int          errors;
		int          results_seen;

		function new();
			longint unsigned u, th, t2, p, sv, mag;
			int unsigned quad, r;
			int unsigned divs [5];
			divs = '{110, 72, 42, 20, 6};
			// Full-turn table from the quarter-wave Taylor polynomial in Q30.
			for (int i = 0; i < TAB_SIZE; i++) begin
				quad = (i / TAB_QUARTER) % 4;
				r = i % TAB_QUARTER;
				u = quad[0] ? TAB_QUARTER - r : r;
				th = (u * PI_HALF_Q30) / TAB_QUARTER;
				t2 = (th * th) >> 30;
				p = UNITY_Q30;
				foreach (divs[j]) p = UNITY_Q30 - ((t2 * p) >> 30) / divs[j];
				sv = (th * p) >> 30;
				mag = (sv * 32767 + (64'd1 << 29)) >> 30;
				if (mag > 32767) mag = 32767;
				sine_tab[i] = (quad >= 2) ? 16'(32768 - mag) : 16'(32768 + mag);
			end
			svpwm_en = ssg_pkg::SVPWM_ENABLE_RST;
			boost_amp = ssg_pkg::BOOST_AMPLITUDE_RST;
			boost_f = ssg_pkg::BOOST_FREQ_RST;
			max_amp = ssg_pkg::MAX_AMPLITUDE_RST;
			weak_f = ssg_pkg::WEAK_FREQ_RST;
			slew_per = ssg_pkg::SLEW_PERIOD_RST;
			phase = '0;
			ramp = '0;
			slew_cnt = '0;
			amp = '0;
			errors = 0;
			results_seen = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH: %s", msg);
		endtask

		function void write_reg(ssg_pkg::reg_idx_t idx, logic [31:0] v);
			unique case (idx)
				ssg_pkg::REG_SVPWM_ENABLE:    svpwm_en = v[0];
				ssg_pkg::REG_BOOST_AMPLITUDE: boost_amp = v[15:0];
				ssg_pkg::REG_BOOST_FREQ:      boost_f = v[14:0];
				ssg_pkg::REG_MAX_AMPLITUDE:   max_amp = v[15:0];
				ssg_pkg::REG_WEAK_FREQ:       weak_f = v[14:0];
				ssg_pkg::REG_SLEW_PERIOD:     slew_per = v[15:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(ssg_pkg::reg_idx_t idx);
			unique case (idx)
				ssg_pkg::REG_SVPWM_ENABLE:    return 32'(svpwm_en);
				ssg_pkg::REG_BOOST_AMPLITUDE: return 32'(boost_amp);
				ssg_pkg::REG_BOOST_FREQ:      return 32'(boost_f);
				ssg_pkg::REG_MAX_AMPLITUDE:   return 32'(max_amp);
				ssg_pkg::REG_WEAK_FREQ:       return 32'(weak_f);
				ssg_pkg::REG_SLEW_PERIOD:     return 32'(slew_per);
				default:                      return '0;
			endcase
		endfunction

		// Table sample at a phase, scaled by amplitude/32768 and floored.
		function longint scaled(logic [15:0] ph);
			longint base;
			base = longint'(sine_tab[ph[15 -: TAB_BITS]]) - 32768;
			return (longint'(amp) * base) >>> 15;
		endfunction

		// Advance the mirrored state by one accepted tick and queue its result.
		task note_tick(logic signed [15:0] sp);
			longint s [3];
			longint mn, mx, ofs, f, p, bf, wf, slope, ramp_line, dd;
			logic [10:0] duty [3];
			pwm_tick_t want;
			// The ramp steps once per slew period; the V/f curve uses the frequency ahead of the step.
			if (slew_cnt >= slew_per) begin
				f = ramp;
				bf = longint'(boost_f);
				wf = longint'(weak_f);
				if (ramp < sp) ramp++;
				else if (ramp > sp) ramp--;
				if (f == 0) begin
					amp = '0;
				end else if (f < bf) begin
					amp = boost_amp;
				end else if (f < wf) begin
					slope = (longint'(max_amp) - longint'(boost_amp)) / (wf - bf);
					ramp_line = longint'(max_amp) - slope * (wf - f);
					amp = ramp_line[15:0];
				end else begin
					amp = max_amp;
				end
				slew_cnt = '0;
			end else begin
				slew_cnt++;
			end
			s[0] = scaled(phase);
			s[1] = scaled(phase + PHASE_THIRD);
			s[2] = scaled(phase + PHASE_TWO_THIRDS);
			// Min/max injection moves the midpoint of the three phases to zero.
			ofs = 0;
			if (svpwm_en) begin
				mn = s[0];
				mx = s[0];
				for (int k = 1; k < 3; k++) begin
					if (s[k] < mn) mn = s[k];
					if (s[k] > mx) mx = s[k];
				end
				ofs = (mn + mx) >>> 1;
			end
			// Duties wrap at 16 bits ahead of the shift, so overmodulation wraps around.
			for (int k = 0; k < 3; k++) begin
				dd = s[k] - ofs + 32768;
				duty[k] = dd[15:5];
			end
			p = longint'(phase);
			f = ramp;
			want.duty_a = duty[0];
			want.duty_b = duty[1];
			want.duty_c = duty[2];
			want.trig_rising = (16384 >= p - f + 1) && (16384 <= p + f - 1);
			want.current_freq = ramp;
			pending.push_back(want);
			phase = phase + ramp;
		endtask

		task check_result(pwm_tick_t got);
			pwm_tick_t want;
			results_seen++;
			if (pending.size() == 0) begin
				report($sformatf("result %0d arrived with no tick pending", results_seen));
				return;
			end
			want = pending.pop_front();
			if (got.duty_a !== want.duty_a)
				report($sformatf("result %0d duty_a %0d, want %0d",
					results_seen, got.duty_a, want.duty_a));
			if (got.duty_b !== want.duty_b)
				report($sformatf("result %0d duty_b %0d, want %0d",
					results_seen, got.duty_b, want.duty_b));
			if (got.duty_c !== want.duty_c)
				report($sformatf("result %0d duty_c %0d, want %0d",
					results_seen, got.duty_c, want.duty_c));
			if (got.trig_rising !== want.trig_rising)
				report($sformatf("result %0d trig_rising %0b, want %0b",
					results_seen, got.trig_rising, want.trig_rising));
			if (got.current_freq !== want.current_freq)
				report($sformatf("result %0d current_freq %0d, want %0d",
					results_seen, got.current_freq, want.current_freq));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] freq_setpoint;
	logic               out_valid;
	logic               out_ready;
	logic [10:0]        duty_a;
	logic [10:0]        duty_b;
	logic [10:0]        duty_c;
	logic               trig_rising;
	logic signed [15:0] current_freq;

	pwm_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	int hold_cycles;
	int unsigned cycle_count;

	sine_svpwm_generator dut (.*);

	// Clock with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver: random stalls, or a long hold-off while a hold count is pending.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Monitor: every input transfer feeds the predictor, every result transfer is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_tick(freq_setpoint);
			if (out_valid && out_ready)
				sb.check_result(pwm_tick_t'{duty_a, duty_b, duty_c, trig_rising, current_freq});
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// One register transfer: a setup phase, then an access phase held until pready.
	task automatic apb_xfer(input logic wr, input logic [4:0] addr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_reg(input ssg_pkg::reg_idx_t idx, input logic [31:0] v);
		logic [31:0] rd;
		apb_xfer(1'b1, {idx, 2'b00}, v, rd);
		sb.write_reg(idx, v);
	endtask

	// Read back every register and compare with the mirrored copy.
	task automatic check_registers();
		logic [31:0] rd;
		for (int i = ssg_pkg::REG_SVPWM_ENABLE; i <= ssg_pkg::REG_SLEW_PERIOD; i++) begin
			apb_xfer(1'b0, 5'(i << 2), '0, rd);
			if (rd !== sb.reg_value(ssg_pkg::reg_idx_t'(i)))
				sb.report($sformatf("register %0d reads %0h, want %0h",
					i, rd, sb.reg_value(ssg_pkg::reg_idx_t'(i))));
		end
	endtask

	task automatic configure(input logic svp, input logic [15:0] b_amp, input logic [14:0] b_f,
			input logic [15:0] m_amp, input logic [14:0] w_f, input logic [15:0] slew);
		set_reg(ssg_pkg::REG_SVPWM_ENABLE, 32'(svp));
		set_reg(ssg_pkg::REG_BOOST_AMPLITUDE, 32'(b_amp));
		set_reg(ssg_pkg::REG_BOOST_FREQ, 32'(b_f));
		set_reg(ssg_pkg::REG_MAX_AMPLITUDE, 32'(m_amp));
		set_reg(ssg_pkg::REG_WEAK_FREQ, 32'(w_f));
		set_reg(ssg_pkg::REG_SLEW_PERIOD, 32'(slew));
		check_registers();
	endtask

	// Offer one tick after an optional random gap; valid stays up until the transfer.
	task automatic send_tick(input logic signed [15:0] sp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		freq_setpoint <= sp;
		do @(posedge clk); while (!in_ready);
	endtask

	// Runs of ticks that chase a random target, mixed with full-range noise setpoints.
	task automatic run_ticks(input int count, input int spread);
		int left;
		int run_len;
		int target;
		logic signed [15:0] sp;
		left = count;
		while (left > 0) begin
			target = int'($urandom_range(2 * spread)) - spread;
			run_len = $urandom_range(60, 10);
			while (run_len > 0 && left > 0) begin
				if ($urandom_range(99) < 12) sp = 16'($urandom);
				else sp = 16'(target + int'($urandom_range(2)) - 1);
				send_tick(sp);
				run_len--;
				left--;
			end
		end
	endtask

	// Stop offering and wait until every predicted result has been transferred.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic signed [15:0] opening [25];
		logic [31:0] rd;
		opening = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
			16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh5555,
			16'shAAAA, 16'sd120, 16'sh7FFE, 16'sh8001, 16'sd2};
		sb = new();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		cycle_count <= 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		freq_setpoint <= '0;
		out_ready <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults, then a stepping ramp through zero, boost and the V/f line.
		check_registers();
		set_reg(ssg_pkg::REG_SLEW_PERIOD, 32'd0);
		foreach (opening[i]) send_tick(opening[i]);
		settle();

		// Rising V/f line reaching maximum amplitude, no idling.
		configure(1'b1, 16'd2000, 15'd10, 16'd40000, 15'd60, 16'd0);
		run_ticks(250, 100);
		settle();

		// Plain sine at full amplitude, so the duties wrap; sender idles.
		send_idle_pct = 55;
		configure(1'b0, 16'd0, 15'd0, 16'd65535, 15'd20, 16'd0);
		run_ticks(250, 60);
		settle();

		// Falling V/f line with a slow ramp; receiver stalls.
		send_idle_pct = 0;
		stall_pct = 55;
		configure(1'b1, 16'd60000, 15'd5, 16'd3000, 15'd40, 16'd1);
		run_ticks(250, 50);
		settle();

		// Frozen ramp at the longest slew period; the receiver first holds off so the block fills.
		send_idle_pct = 36;
		stall_pct = 36;
		configure(1'b1, 16'd65535, 15'd32767, 16'd0, 15'd32767, 16'd65535);
		hold_cycles = 300;
		run_ticks(150, 200);
		settle();

		// A write past the last register changes nothing; then a lowered slew period steps at once.
		apb_xfer(1'b1, UNMAPPED_ADDR, 32'hFFFF_FFFF, rd);
		configure(1'b0, 16'd65535, 15'd0, 16'd0, 15'd0, 16'd2);
		run_ticks(250, 100);
		settle();

		// Back to the reset curve with a fast ramp, no idling.
		send_idle_pct = 0;
		stall_pct = 0;
		configure(ssg_pkg::SVPWM_ENABLE_RST, ssg_pkg::BOOST_AMPLITUDE_RST, ssg_pkg::BOOST_FREQ_RST,
			ssg_pkg::MAX_AMPLITUDE_RST, ssg_pkg::WEAK_FREQ_RST, 16'd0);
		run_ticks(200, 180);
		settle();

		if (sb.pending.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending.size()));
		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
